@@ hw/rtl/scs_pkg.sv @@
// Shared types, codes and helpers for the sensor calibrate-and-smooth block.
// Used by scs_regs, scs_ctrl, scs_dp and the top level; no dependencies.
`default_nettype none

package scs_pkg;

  // Wide signed working type: holds any 33x33 product plus rounding headroom
  typedef logic signed [65:0] wide_t;

  // value_mode codes; the unused code behaves as plain linear
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ANGLE = 2'd1;
  localparam logic [1:0] MODE_TEMP  = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_CAL_OFFSET    = 2'd0;
  localparam logic [1:0] REG_CAL_SLOPE     = 2'd1;
  localparam logic [1:0] REG_SMOOTH_FACTOR = 2'd2;
  localparam logic [1:0] REG_VALUE_MODE    = 2'd3;

  // Smoothing weight is always unsigned Q1.16 (one = 65536)
  localparam logic [16:0] SMOOTH_ONE   = 17'd65536;
  localparam int          SMOOTH_SHIFT = 16;

  // 273.15 scaled by 100, and 2*pi in Q32.32
  localparam logic [63:0] KELVIN_X100 = 64'd27315;
  localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;

  // Configuration register set
  typedef struct packed {
    logic signed [31:0] cal_offset;
    logic signed [31:0] cal_slope;
    logic [16:0]        smooth_factor;
    logic [1:0]         value_mode;
  } cfg_t;

  // Datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_MUL,
    OP_CAL,
    OP_POST,
    OP_MODQ,
    OP_MODM,
    OP_MODR,
    OP_MODS,
    OP_SMD,
    OP_SMM,
    OP_SMA,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_angle;
    logic have_prev;
  } stat_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL,
    ST_CAL,
    ST_POST,
    ST_MODQ,
    ST_MODM,
    ST_MODR,
    ST_MODS,
    ST_SMD,
    ST_SMM,
    ST_SMA,
    ST_DONE
  } state_e;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(wide_t v);
    logic signed [31:0] r;
    if (v[65:31] != {35{v[65]}}) begin
      r = v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scs_regs.sv @@
// APB-style configuration registers for the calibrate-and-smooth block.
// Depends on scs_pkg (cfg_t, register indexes).
`default_nettype none

module scs_regs #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output scs_pkg::cfg_t      cfg_o
);

  scs_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        scs_pkg::REG_CAL_OFFSET:    cfg_d.cal_offset    = pwdata;
        scs_pkg::REG_CAL_SLOPE:     cfg_d.cal_slope     = pwdata;
        scs_pkg::REG_SMOOTH_FACTOR: cfg_d.smooth_factor = pwdata[16:0];
        scs_pkg::REG_VALUE_MODE:    cfg_d.value_mode    = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_offset    <= '0;
      cfg_q.cal_slope     <= 32'(64'd1 << FRAC_BITS);
      cfg_q.smooth_factor <= scs_pkg::SMOOTH_ONE;
      cfg_q.value_mode    <= scs_pkg::MODE_PLAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      scs_pkg::REG_CAL_OFFSET:    prdata = cfg_q.cal_offset;
      scs_pkg::REG_CAL_SLOPE:     prdata = cfg_q.cal_slope;
      scs_pkg::REG_SMOOTH_FACTOR: prdata = {15'd0, cfg_q.smooth_factor};
      scs_pkg::REG_VALUE_MODE:    prdata = {30'd0, cfg_q.value_mode};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/scs_dp.sv @@
// Datapath: operand registers, one shared 33x33 multiplier, saturation and
// the 2*pi reduction. Steps are driven by scs_ctrl; depends on scs_pkg.
`default_nettype none

module scs_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  scs_pkg::cmd_t            cmd_i,
  input  scs_pkg::cfg_t            cfg_i,
  input  wire logic signed [31:0]  sample_i,
  input  wire logic                sample_valid_i,
  output scs_pkg::stat_t           stat_o,
  output logic signed [31:0]       result_value_o,
  output logic                     calibrated_o
);

  // Fixed-point constants computed at elaboration: Kelvin offset and 2*pi rounded to nearest, reciprocal rounded down
  localparam logic [63:0] KelvinQ =
      ((scs_pkg::KELVIN_X100 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] TwoPiQ =
      (scs_pkg::TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] RecipQ = (64'd1 << 32) / TwoPiQ;
  localparam logic [31:0] Tp32    = TwoPiQ[31:0];
  localparam logic [32:0] Recip33 = RecipQ[32:0];
  localparam scs_pkg::wide_t KelvinW  = scs_pkg::wide_t'(KelvinQ);
  localparam scs_pkg::wide_t HalfCal  = scs_pkg::wide_t'(64'd1 << (FRAC_BITS - 1));
  localparam scs_pkg::wide_t HalfSm   =
      scs_pkg::wide_t'(64'd1 << (scs_pkg::SMOOTH_SHIFT - 1));

  logic signed [31:0] x_q;
  logic               vld_q;
  logic signed [31:0] acc_q, acc_d;
  logic [31:0]        mag_q, mag_d;
  logic               neg_q, neg_d;
  scs_pkg::wide_t     prod_q, prod;
  logic signed [31:0] prev_q;
  logic               have_prev_q;
  logic signed [31:0] res_q;
  logic               cal_q;

  logic signed [32:0] mul_a, mul_b;
  logic [16:0]        factor;
  logic signed [31:0] cal_scaled;
  logic signed [31:0] sm_step;
  logic [32:0]        mod_rem;
  logic               is_mul;

  assign stat_o.is_angle  = (cfg_i.value_mode == scs_pkg::MODE_ANGLE);
  assign stat_o.have_prev = have_prev_q;
  assign result_value_o   = res_q;
  assign calibrated_o     = cal_q;

  // Weight above one acts as one
  assign factor = (cfg_i.smooth_factor > scs_pkg::SMOOTH_ONE) ?
                  scs_pkg::SMOOTH_ONE : cfg_i.smooth_factor;

  // Shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    case (cmd_i.op)
      scs_pkg::OP_MUL: begin
        mul_a = 33'(acc_q);
        mul_b = 33'(cfg_i.cal_slope);
      end
      scs_pkg::OP_MODQ: begin
        mul_a = {1'b0, mag_q};
        mul_b = Recip33;
      end
      scs_pkg::OP_MODM: begin
        mul_a = {1'b0, prod_q[63:32]};
        mul_b = {1'b0, Tp32};
      end
      scs_pkg::OP_SMM: begin
        mul_a = 33'(acc_q);
        mul_b = {16'd0, factor};
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round half up, floor shift, saturate, then add the offset and saturate again
  assign cal_scaled = scs_pkg::sat32(
      scs_pkg::wide_t'(scs_pkg::sat32((prod_q + HalfCal) >>> FRAC_BITS)) +
      scs_pkg::wide_t'(cfg_i.cal_offset));

  // Smoothing step: prev + round(d * f)
  assign sm_step = scs_pkg::sat32(
      scs_pkg::wide_t'(prev_q) +
      scs_pkg::wide_t'(scs_pkg::sat32((prod_q + HalfSm) >>> scs_pkg::SMOOTH_SHIFT)));

  // Remainder after the reciprocal estimate, in [0, 2*tp)
  assign mod_rem = {1'b0, mag_q} - prod_q[32:0];

  // Working-register updates
  always_comb begin
    acc_d = acc_q;
    mag_d = mag_q;
    neg_d = neg_q;
    case (cmd_i.op)
      scs_pkg::OP_PRE: begin
        if (cfg_i.value_mode == scs_pkg::MODE_TEMP) begin
          acc_d = scs_pkg::sat32(scs_pkg::wide_t'(x_q) - KelvinW);
        end else begin
          acc_d = x_q;
        end
      end
      scs_pkg::OP_CAL: acc_d = cal_scaled;
      scs_pkg::OP_POST: begin
        if (cfg_i.value_mode == scs_pkg::MODE_TEMP) begin
          acc_d = scs_pkg::sat32(scs_pkg::wide_t'(acc_q) + KelvinW);
        end
        neg_d = acc_q[31];
        mag_d = acc_q[31] ? 32'(33'd0 - 33'(acc_q)) : 32'(acc_q);
      end
      scs_pkg::OP_MODR: begin
        mag_d = (mod_rem >= {1'b0, Tp32}) ? 32'(mod_rem - {1'b0, Tp32}) : mod_rem[31:0];
      end
      scs_pkg::OP_MODS: begin
        acc_d = (neg_q && (mag_q != '0)) ? signed'(Tp32 - mag_q) : signed'(mag_q);
      end
      scs_pkg::OP_SMD: begin
        acc_d = scs_pkg::sat32(scs_pkg::wide_t'(acc_q) - scs_pkg::wide_t'(prev_q));
      end
      scs_pkg::OP_SMA: acc_d = sm_step;
      default: ;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    if (is_mul) begin
      prod_q <= prod;
    end
    if (cmd_i.op == scs_pkg::OP_LOAD) begin
      x_q   <= sample_i;
      vld_q <= sample_valid_i;
    end
    if (cmd_i.op == scs_pkg::OP_OUT) begin
      res_q <= vld_q ? acc_q : x_q;
      cal_q <= vld_q;
    end
  end

  // Channel state: previous value and its flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if ((cmd_i.op == scs_pkg::OP_OUT) && vld_q) begin
      prev_q      <= acc_q;
      have_prev_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scs_ctrl.sv @@
// Controller state machine: sequences datapath steps and owns the handshakes.
// Depends on scs_pkg (state_e, cmd_t, stat_t).
`default_nettype none

module scs_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        sample_valid_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  scs_pkg::stat_t   stat_i,
  output scs_pkg::cmd_t    cmd_o
);

  scs_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;
  logic            load_out;

  assign in_stall_o  = (state_q != scs_pkg::ST_IDLE);
  assign accept      = in_valid_i && (state_q == scs_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == scs_pkg::ST_DONE) && out_free;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sample_valid_i ? scs_pkg::ST_PRE : scs_pkg::ST_DONE;
        end
      end
      scs_pkg::ST_PRE:  state_d = scs_pkg::ST_MUL;
      scs_pkg::ST_MUL:  state_d = scs_pkg::ST_CAL;
      scs_pkg::ST_CAL:  state_d = scs_pkg::ST_POST;
      scs_pkg::ST_POST: begin
        if (stat_i.is_angle) begin
          state_d = scs_pkg::ST_MODQ;
        end else begin
          state_d = stat_i.have_prev ? scs_pkg::ST_SMD : scs_pkg::ST_DONE;
        end
      end
      scs_pkg::ST_MODQ: state_d = scs_pkg::ST_MODM;
      scs_pkg::ST_MODM: state_d = scs_pkg::ST_MODR;
      scs_pkg::ST_MODR: state_d = scs_pkg::ST_MODS;
      scs_pkg::ST_MODS: state_d = stat_i.have_prev ? scs_pkg::ST_SMD : scs_pkg::ST_DONE;
      scs_pkg::ST_SMD:  state_d = scs_pkg::ST_SMM;
      scs_pkg::ST_SMM:  state_d = scs_pkg::ST_SMA;
      scs_pkg::ST_SMA:  state_d = scs_pkg::ST_DONE;
      scs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = scs_pkg::ST_IDLE;
        end
      end
      default: state_d = scs_pkg::ST_IDLE;
    endcase
  end

  // Datapath command per state
  always_comb begin
    case (state_q)
      scs_pkg::ST_IDLE: cmd_o.op = accept ? scs_pkg::OP_LOAD : scs_pkg::OP_NONE;
      scs_pkg::ST_PRE:  cmd_o.op = scs_pkg::OP_PRE;
      scs_pkg::ST_MUL:  cmd_o.op = scs_pkg::OP_MUL;
      scs_pkg::ST_CAL:  cmd_o.op = scs_pkg::OP_CAL;
      scs_pkg::ST_POST: cmd_o.op = scs_pkg::OP_POST;
      scs_pkg::ST_MODQ: cmd_o.op = scs_pkg::OP_MODQ;
      scs_pkg::ST_MODM: cmd_o.op = scs_pkg::OP_MODM;
      scs_pkg::ST_MODR: cmd_o.op = scs_pkg::OP_MODR;
      scs_pkg::ST_MODS: cmd_o.op = scs_pkg::OP_MODS;
      scs_pkg::ST_SMD:  cmd_o.op = scs_pkg::OP_SMD;
      scs_pkg::ST_SMM:  cmd_o.op = scs_pkg::OP_SMM;
      scs_pkg::ST_SMA:  cmd_o.op = scs_pkg::OP_SMA;
      scs_pkg::ST_DONE: cmd_o.op = out_free ? scs_pkg::OP_OUT : scs_pkg::OP_NONE;
      default:          cmd_o.op = scs_pkg::OP_NONE;
    endcase
  end

  // Output register valid: held while stalled, set on load
  assign out_valid_d = (out_valid_q && out_stall_i) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != scs_pkg::ST_IDLE))
    else $error("accepted transaction did not leave idle");

  // Loading the result register always presents a result next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("result load did not raise out_valid");

  // Smoothing only runs once the store is primed
  a_smooth_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scs_pkg::ST_SMD) |-> stat_i.have_prev)
    else $error("smoothing without a previous value");

  // The 2*pi reduction only runs in angle mode
  a_mod_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scs_pkg::ST_MODQ) |-> stat_i.is_angle)
    else $error("angle reduction outside angle mode");

endmodule

`default_nettype wire

@@ hw/rtl/sensor_calibrate_and_smooth_top.sv @@
// Accept to result valid: an invalid sample goes straight to DONE; a valid sample
// runs PRE, MUL, CAL, POST, plus SMD, SMM, SMA once the store is primed, and angle
// mode adds MODQ, MODM, MODR, MODS (2*pi reduction) after POST. A sample is taken
// only in IDLE, so each is sequenced through the one shared 33x33 multiplier in turn.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_ni low, asynchronous) clears the state and loads register defaults.
`default_nettype none

module sensor_calibrate_and_smooth_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Sample channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] sample_i,
  input  wire logic               sample_valid_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      result_value_o,
  output logic                    calibrated_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  scs_pkg::cfg_t  cfg;
  scs_pkg::cmd_t  cmd;
  scs_pkg::stat_t stat;

  // Configuration registers
  scs_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer
  scs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_valid_i (sample_valid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // Arithmetic
  scs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .stat_o         (stat),
    .result_value_o (result_value_o),
    .calibrated_o   (calibrated_o)
  );

endmodule

`default_nettype wire
